/* rtl/core/wbc_pkg.sv */
// shared types and codes of the write-back block cache controller
package wbc_pkg;

  localparam int unsigned BlkW  = 48;
  localparam int unsigned SlotW = 5;

  typedef enum logic [2:0] {
    CMD_GET    = 3'd0,
    CMD_PUT    = 3'd1,
    CMD_MARK   = 3'd2,
    CMD_BEGIN  = 3'd3,
    CMD_COMMIT = 3'd4,
    CMD_ABORT  = 3'd5,
    CMD_SYNC   = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    K_DONE  = 3'd0,
    K_READ  = 3'd1,
    K_WB    = 3'd2,
    K_ZFILL = 3'd3,
    K_FLUSH = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_NOEVICT = 3'd2,
    ST_NOTC    = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_VSCAN,
    S_VWB,
    S_VFILL,
    S_GDONE,
    S_CSCAN,
    S_ASCAN,
    S_SSCAN
  } state_e;

  // operation broadcast along the row of slot cells
  typedef struct packed {
    logic alloc;
    logic zf;
    logic pin_inc;
    logic pin_dec;
    logic set_dirty;
    logic clr_dirty;
    logic set_txn;
    logic clr_txn;
    logic kill;
    logic touch;
  } cell_op_t;

endpackage

/* rtl/core/wbc_if.sv */
// handshake interfaces for the command and result channels

interface wbc_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [47:0] block;
  logic        zero_fill;
  modport source (output valid, command, block, zero_fill, input ready);
  modport sink (input valid, command, block, zero_fill, output ready);
endinterface

interface wbc_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [47:0] block_number;
  logic [4:0]  slot;
  logic [2:0]  status;
  logic        last;
  modport source (output valid, kind, block_number, slot, status, last, input ready);
  modport sink (input valid, kind, block_number, slot, status, last, output ready);
endinterface

/* rtl/core/writeback_block_cache_with_transactions.sv */
// top level of the write-back block cache metadata controller
//
//  channel   dir   handshake          payload
//  cmd_i     in    valid/ready        command, block, zero_fill
//  res_o     out   valid/ready        kind, block_number, slot, status, last
//  cfg       in    cfg_we_i           cfg_wdata_i (device_blocks)
//
// one command at a time: cmd_i is ready only while the sequencer is idle
// put, mark, begin, unknown and out-of-range get answer from decode, a hit get from a done step
// a miss get walks the lru ranks one per cycle from coldest to find its victim
// commit and abort walk the listed blocks, sync walks every slot
// each word waits in a single output register; a stalled sink holds the sequencer
// reset empties all slots and sets slot i to lru rank i, no clearing pass
module writeback_block_cache_with_transactions #(
  parameter int unsigned ENTRIES    = 32,
  parameter int unsigned TXN_MAX    = 16,
  parameter int unsigned BLOCK_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wbc_cmd_if.sink     cmd_i,
  wbc_res_if.source   res_o,
  input  logic        cfg_we_i,
  input  logic [47:0] cfg_wdata_i
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(TXN_MAX + 1);
  localparam int unsigned LW = (TXN_MAX > 1) ? $clog2(TXN_MAX) : 1;

  // sequencer and command registers
  wbc_pkg::state_e       state_q, state_d;
  wbc_pkg::cmd_e         cmd_q;
  logic [BLOCK_BITS-1:0] blk_q;
  logic                  zf_q;
  logic [IW-1:0]         s_q, s_d;
  logic [IW:0]           sc_q, sc_d;
  logic [CW-1:0]         ti_q, ti_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  open_q, open_d;
  logic [BLOCK_BITS-1:0] dev_q;
  logic [BLOCK_BITS-1:0] list_q [TXN_MAX];
  logic                  lwe;

  // output register
  logic                  ovalid_q;
  logic [2:0]            okind_q, ost_q;
  logic [47:0]           oblk_q;
  logic [4:0]            oslot_q;
  logic                  emit;
  wbc_pkg::kind_e        e_kind;
  wbc_pkg::status_e      e_st;
  logic [BLOCK_BITS-1:0] e_blk;
  logic [IW-1:0]         e_slot;
  logic                  can_emit;

  // cell row
  wbc_pkg::cell_op_t     op;
  logic [IW-1:0]         tgt;
  logic [BLOCK_BITS-1:0] key;
  logic [ENTRIES-1:0]    hit_v, valid_v, dirty_v, txn_v, ok_v, rmatch_v, elig_v;
  logic [BLOCK_BITS-1:0] tag_w  [ENTRIES];
  logic [IW-1:0]         rank_w [ENTRIES];
  logic [IW-1:0]         hit_idx, elig_idx;
  logic                  hit, elig, out_range, accept;

  assign accept       = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready  = (state_q == wbc_pkg::S_IDLE);
  assign can_emit     = !ovalid_q || res_o.ready;
  assign out_range    = (blk_q >= dev_q);

  // transaction scans look up listed blocks, everything else the command block
  assign key = (state_q == wbc_pkg::S_CSCAN || state_q == wbc_pkg::S_ASCAN)
             ? list_q[ti_q[LW-1:0]] : blk_q;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    wbc_slot_cell #(
      .ENTRIES    (ENTRIES),
      .BLOCK_BITS (BLOCK_BITS),
      .IDX        (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .sel_i        (tgt == IW'(g)),
      .op_i         (op),
      .tag_i        (blk_q),
      .key_i        (key),
      .touch_rank_i (rank_w[tgt]),
      .hit_o        (hit_v[g]),
      .valid_o      (valid_v[g]),
      .dirty_o      (dirty_v[g]),
      .txn_o        (txn_v[g]),
      .evict_ok_o   (ok_v[g]),
      .tag_o        (tag_w[g]),
      .rank_o       (rank_w[g])
    );
    assign rmatch_v[g] = (rank_w[g] == sc_q[IW-1:0]);
  end

  assign elig_v = rmatch_v & ok_v;
  assign hit    = |hit_v;
  assign elig   = |elig_v;

  // one-hot to index
  always_comb begin
    hit_idx  = '0;
    elig_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_v[i])  hit_idx  = hit_idx  | IW'(i);
      if (elig_v[i]) elig_idx = elig_idx | IW'(i);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wbc_pkg::S_IDLE: begin
        if (accept) state_d = wbc_pkg::S_DECODE;
      end
      wbc_pkg::S_DECODE: begin
        case (cmd_q)
          wbc_pkg::CMD_GET: begin
            if (out_range) begin
              if (can_emit) state_d = wbc_pkg::S_IDLE;
            end else if (hit) begin
              state_d = wbc_pkg::S_GDONE;
            end else begin
              state_d = wbc_pkg::S_VSCAN;
            end
          end
          wbc_pkg::CMD_COMMIT: state_d = wbc_pkg::S_CSCAN;
          wbc_pkg::CMD_ABORT:  state_d = wbc_pkg::S_ASCAN;
          wbc_pkg::CMD_SYNC:   state_d = wbc_pkg::S_SSCAN;
          default: begin
            if (can_emit) state_d = wbc_pkg::S_IDLE;
          end
        endcase
      end
      wbc_pkg::S_VSCAN: begin
        if (elig) state_d = wbc_pkg::S_VWB;
        else if (sc_q == (IW+1)'(ENTRIES - 1) && can_emit) state_d = wbc_pkg::S_IDLE;
      end
      wbc_pkg::S_VWB: begin
        if (!(valid_v[s_q] && dirty_v[s_q]) || can_emit) state_d = wbc_pkg::S_VFILL;
      end
      wbc_pkg::S_VFILL: begin
        if (can_emit) state_d = wbc_pkg::S_GDONE;
      end
      wbc_pkg::S_GDONE: begin
        if (can_emit) state_d = wbc_pkg::S_IDLE;
      end
      wbc_pkg::S_CSCAN: begin
        if ((ti_q == cnt_q || !hit) && can_emit) state_d = wbc_pkg::S_IDLE;
      end
      wbc_pkg::S_ASCAN: begin
        if (ti_q == cnt_q && can_emit) state_d = wbc_pkg::S_IDLE;
      end
      wbc_pkg::S_SSCAN: begin
        if (sc_q == (IW+1)'(ENTRIES) && can_emit) state_d = wbc_pkg::S_IDLE;
      end
      default: state_d = wbc_pkg::S_IDLE;
    endcase
  end

  // cell operations, counters and result words
  always_comb begin
    op     = '0;
    tgt    = s_q;
    emit   = 1'b0;
    e_kind = wbc_pkg::K_DONE;
    e_st   = wbc_pkg::ST_OK;
    e_blk  = '0;
    e_slot = '0;
    s_d    = s_q;
    sc_d   = sc_q;
    ti_d   = ti_q;
    cnt_d  = cnt_q;
    open_d = open_q;
    lwe    = 1'b0;
    case (state_q)
      wbc_pkg::S_IDLE: begin
        sc_d = '0;
        ti_d = '0;
      end
      wbc_pkg::S_DECODE: begin
        case (cmd_q)
          wbc_pkg::CMD_GET: begin
            if (out_range) begin
              emit = can_emit;
              e_st = wbc_pkg::ST_RANGE;
            end else if (hit) begin
              s_d = hit_idx;
            end
          end
          wbc_pkg::CMD_PUT: begin
            tgt = hit_idx;
            if (can_emit) begin
              emit       = 1'b1;
              e_slot     = hit_idx;
              op.pin_dec = hit;
            end
          end
          wbc_pkg::CMD_MARK: begin
            tgt = hit_idx;
            if (can_emit) begin
              emit = 1'b1;
              if (!hit) begin
                e_st = wbc_pkg::ST_NOTC;
              end else begin
                e_slot       = hit_idx;
                op.set_dirty = 1'b1;
                if (open_q && !txn_v[hit_idx]) begin
                  if (cnt_q >= CW'(TXN_MAX)) begin
                    e_st = wbc_pkg::ST_FULL;
                  end else begin
                    op.set_txn = 1'b1;
                    lwe        = 1'b1;
                    cnt_d      = cnt_q + CW'(1);
                  end
                end
              end
            end
          end
          wbc_pkg::CMD_BEGIN: begin
            if (can_emit) begin
              emit   = 1'b1;
              open_d = 1'b1;
              cnt_d  = '0;
            end
          end
          wbc_pkg::CMD_COMMIT, wbc_pkg::CMD_ABORT, wbc_pkg::CMD_SYNC: begin
          end
          default: emit = can_emit;
        endcase
      end
      wbc_pkg::S_VSCAN: begin
        if (elig) begin
          s_d = elig_idx;
        end else if (sc_q == (IW+1)'(ENTRIES - 1)) begin
          emit = can_emit;
          e_st = wbc_pkg::ST_NOEVICT;
        end else begin
          sc_d = sc_q + (IW+1)'(1);
        end
      end
      wbc_pkg::S_VWB: begin
        if (valid_v[s_q] && dirty_v[s_q] && can_emit) begin
          emit         = 1'b1;
          e_kind       = wbc_pkg::K_WB;
          e_blk        = tag_w[s_q];
          e_slot       = s_q;
          op.clr_dirty = 1'b1;
        end
      end
      wbc_pkg::S_VFILL: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_kind   = zf_q ? wbc_pkg::K_ZFILL : wbc_pkg::K_READ;
          e_blk    = blk_q;
          e_slot   = s_q;
          op.alloc = 1'b1;
          op.zf    = zf_q;
        end
      end
      wbc_pkg::S_GDONE: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_slot     = s_q;
          op.pin_inc = 1'b1;
          op.touch   = 1'b1;
        end
      end
      wbc_pkg::S_CSCAN: begin
        tgt = hit_idx;
        if (ti_q == cnt_q || !hit) begin
          if (can_emit) begin
            emit   = 1'b1;
            e_kind = (ti_q == cnt_q) ? wbc_pkg::K_FLUSH : wbc_pkg::K_DONE;
            e_st   = (ti_q == cnt_q) ? wbc_pkg::ST_OK : wbc_pkg::ST_NOTC;
            open_d = 1'b0;
            cnt_d  = '0;
          end
        end else if (dirty_v[hit_idx]) begin
          if (can_emit) begin
            emit         = 1'b1;
            e_kind       = wbc_pkg::K_WB;
            e_blk        = tag_w[hit_idx];
            e_slot       = hit_idx;
            op.clr_dirty = 1'b1;
            op.clr_txn   = 1'b1;
            ti_d         = ti_q + CW'(1);
          end
        end else begin
          op.clr_txn = 1'b1;
          ti_d       = ti_q + CW'(1);
        end
      end
      wbc_pkg::S_ASCAN: begin
        tgt = hit_idx;
        if (ti_q == cnt_q) begin
          if (can_emit) begin
            emit   = 1'b1;
            open_d = 1'b0;
            cnt_d  = '0;
          end
        end else begin
          op.kill = hit;
          ti_d    = ti_q + CW'(1);
        end
      end
      wbc_pkg::S_SSCAN: begin
        tgt = sc_q[IW-1:0];
        if (sc_q == (IW+1)'(ENTRIES)) begin
          if (can_emit) begin
            emit   = 1'b1;
            e_kind = wbc_pkg::K_FLUSH;
          end
        end else if (valid_v[sc_q[IW-1:0]] && dirty_v[sc_q[IW-1:0]]) begin
          if (can_emit) begin
            emit         = 1'b1;
            e_kind       = wbc_pkg::K_WB;
            e_blk        = tag_w[sc_q[IW-1:0]];
            e_slot       = sc_q[IW-1:0];
            op.clr_dirty = 1'b1;
            sc_d         = sc_q + (IW+1)'(1);
          end
        end else begin
          sc_d = sc_q + (IW+1)'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wbc_pkg::S_IDLE;
      s_q      <= '0;
      sc_q     <= '0;
      ti_q     <= '0;
      cnt_q    <= '0;
      open_q   <= 1'b0;
      dev_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      s_q     <= s_d;
      sc_q    <= sc_d;
      ti_q    <= ti_d;
      cnt_q   <= cnt_d;
      open_q  <= open_d;
      if (cfg_we_i) dev_q <= BLOCK_BITS'(cfg_wdata_i);
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (res_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= wbc_pkg::cmd_e'(cmd_i.command);
      blk_q <= BLOCK_BITS'(cmd_i.block);
      zf_q  <= cmd_i.zero_fill;
    end
    if (lwe) list_q[cnt_q[LW-1:0]] <= blk_q;
    if (emit) begin
      okind_q <= e_kind;
      ost_q   <= e_st;
      oblk_q  <= 48'(e_blk);
      oslot_q <= 5'(e_slot);
    end
  end

  assign res_o.valid        = ovalid_q;
  assign res_o.kind         = okind_q;
  assign res_o.block_number = oblk_q;
  assign res_o.slot         = oslot_q;
  assign res_o.status       = ost_q;
  // every terminal word comes from a state that returns to idle
  assign res_o.last         = (okind_q == wbc_pkg::K_DONE) || (okind_q == wbc_pkg::K_FLUSH);

  // lru ranks form a permutation, so exactly one slot sits at each rank
  a_rank_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wbc_pkg::S_VSCAN |-> $onehot(rmatch_v))
    else $error("lru rank not unique");

  // a block is cached in at most one slot; the key past the list end is not a block
  a_hit_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((state_q == wbc_pkg::S_CSCAN || state_q == wbc_pkg::S_ASCAN) && ti_q == cnt_q)
    |-> $onehot0(hit_v))
    else $error("block cached twice");

  // the transaction list never overflows
  a_txn_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TXN_MAX))
    else $error("transaction list overflow");

  // a new word never overwrites one that the sink has not taken
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && ovalid_q |-> res_o.ready)
    else $error("result word overwritten");

endmodule

/* rtl/core/wbc_slot_cell.sv */
// one cache slot: tag, valid, pins, dirty, transaction mark and lru rank
module wbc_slot_cell #(
  parameter int unsigned ENTRIES    = 32,
  parameter int unsigned BLOCK_BITS = 48,
  parameter int unsigned IDX        = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sel_i,
  input  wbc_pkg::cell_op_t            op_i,
  input  logic [BLOCK_BITS-1:0]        tag_i,
  input  logic [BLOCK_BITS-1:0]        key_i,
  input  logic [$clog2(ENTRIES)-1:0]   touch_rank_i,
  output logic                         hit_o,
  output logic                         valid_o,
  output logic                         dirty_o,
  output logic                         txn_o,
  output logic                         evict_ok_o,
  output logic [BLOCK_BITS-1:0]        tag_o,
  output logic [$clog2(ENTRIES)-1:0]   rank_o
);

  localparam int unsigned RW = $clog2(ENTRIES);

  logic [BLOCK_BITS-1:0] tag_q;
  logic                  valid_q, dirty_q, txn_q;
  logic [7:0]            pins_q;
  logic [RW-1:0]         rank_q;

  always_ff @(posedge clk_i) begin
    if (sel_i && op_i.alloc) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      txn_q   <= 1'b0;
      pins_q  <= '0;
      rank_q  <= RW'(IDX);
    end else begin
      if (sel_i) begin
        if (op_i.alloc) begin
          valid_q <= 1'b1;
          dirty_q <= op_i.zf;
          txn_q   <= 1'b0;
          pins_q  <= '0;
        end
        if (op_i.kill) begin
          valid_q <= 1'b0;
          dirty_q <= 1'b0;
          txn_q   <= 1'b0;
          pins_q  <= '0;
        end
        if (op_i.set_dirty) dirty_q <= 1'b1;
        if (op_i.clr_dirty) dirty_q <= 1'b0;
        if (op_i.set_txn)   txn_q   <= 1'b1;
        if (op_i.clr_txn)   txn_q   <= 1'b0;
        if (op_i.pin_inc && pins_q != 8'hff) pins_q <= pins_q + 8'd1;
        if (op_i.pin_dec && pins_q != 8'h00) pins_q <= pins_q - 8'd1;
      end
      // move to hottest, everything hotter than the old place shifts down
      if (op_i.touch) begin
        if (sel_i) begin
          rank_q <= RW'(ENTRIES - 1);
        end else if (rank_q > touch_rank_i) begin
          rank_q <= rank_q - RW'(1);
        end
      end
    end
  end

  assign hit_o      = valid_q && (tag_q == key_i);
  assign valid_o    = valid_q;
  assign dirty_o    = dirty_q;
  assign txn_o      = txn_q;
  assign evict_ok_o = !valid_q || (pins_q == 8'h00 && !txn_q);
  assign tag_o      = tag_q;
  assign rank_o     = rank_q;

endmodule

/* dv/tb_writeback_block_cache_with_transactions.sv */
// testbench for the write-back block cache metadata controller
`timescale 1ns / 100ps

module tb_writeback_block_cache_with_transactions;

  localparam int unsigned BlkW     = wbc_pkg::BlkW;
  localparam int unsigned SlotW    = wbc_pkg::SlotW;
  localparam int unsigned Slots    = 32;
  localparam int unsigned TxnDepth = 16;
  localparam logic [2:0]  CmdUnknown = 3'd7;
  localparam int unsigned DrainCycles = 80;   // covers a full sync pass or a miss get that walks every lru rank
  localparam int unsigned HangLimit   = 3000;
  localparam int unsigned StallCycles = 300;
  localparam logic [BlkW-1:0] BlkMax = '1;

  typedef struct packed {
    logic [2:0]      command;
    logic [BlkW-1:0] block;
    logic            zero_fill;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [BlkW-1:0]  block_number;
    logic [SlotW-1:0] slot;
    logic [2:0]       status;
    logic             last;
  } res_word_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [47:0] cfg_wdata_i;

  wbc_cmd_if cmd ();
  wbc_res_if res ();

  writeback_block_cache_with_transactions uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .res_o      (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // mirror of the cache metadata
  logic [BlkW-1:0] m_tag   [Slots];
  logic            m_valid [Slots];
  logic [7:0]      m_pins  [Slots];
  logic            m_dirty [Slots];
  logic            m_in_txn[Slots];
  int unsigned     m_rank  [Slots];   // slot at each lru rank, coldest first
  logic [BlkW-1:0] m_txn   [TxnDepth];
  int unsigned     m_txn_n;
  logic            m_txn_open;
  logic [BlkW-1:0] m_dev_blocks;

  cmd_word_t   pending_cmds[$];
  res_word_t   expected_res[$];
  int unsigned errors;
  int unsigned res_seen;
  int unsigned stall_left;
  int unsigned hang_count;
  bit          stall_done;
  bit          cmd_taken;
  bit          calm;
  logic [BlkW-1:0] blk_pool[$];

  // random idling, but none in one stretch of the run
  function automatic bit idle_now();
    if (calm) return 1'b0;
    return $urandom_range(99) < 17;
  endfunction

  function automatic int lookup_slot(logic [BlkW-1:0] b);
    for (int i = 0; i < Slots; i++)
      if (m_valid[i] && m_tag[i] == b) return i;
    return -1;
  endfunction

  function automatic void push_res(wbc_pkg::kind_e k, logic [BlkW-1:0] b, int unsigned s,
                                   wbc_pkg::status_e st, logic l);
    res_word_t r;
    r.kind = k;
    r.block_number = b;
    r.slot = s[SlotW-1:0];
    r.status = st;
    r.last = l;
    expected_res.push_back(r);
  endfunction

  function automatic void move_to_hot(int unsigned s);
    int pos;
    pos = -1;
    for (int i = 0; i < Slots; i++)
      if (m_rank[i] == s) begin
        pos = i;
        break;
      end
    if (pos < 0) return;
    for (int i = pos; i < Slots - 1; i++) m_rank[i] = m_rank[i+1];
    m_rank[Slots-1] = s;
  endfunction

  function automatic void flush_slot(int unsigned s);
    push_res(wbc_pkg::K_WB, m_tag[s], s, wbc_pkg::ST_OK, 1'b0);
    m_dirty[s] = 1'b0;
  endfunction

  // expected words of one accepted command, with the metadata update
  function automatic void cache_predict(cmd_word_t c);
    int s;
    bit bad;
    s = -1;
    bad = 1'b0;
    case (c.command)
      wbc_pkg::CMD_GET: begin
        if (c.block >= m_dev_blocks) begin
          push_res(wbc_pkg::K_DONE, '0, 0, wbc_pkg::ST_RANGE, 1'b1);
          return;
        end
        s = lookup_slot(c.block);
        if (s < 0) begin
          // victim: coldest slot that is empty, or unpinned and outside the transaction
          for (int i = 0; i < Slots; i++)
            if (!m_valid[m_rank[i]] || (m_pins[m_rank[i]] == 0 && !m_in_txn[m_rank[i]])) begin
              s = m_rank[i];
              break;
            end
          if (s < 0) begin
            push_res(wbc_pkg::K_DONE, '0, 0, wbc_pkg::ST_NOEVICT, 1'b1);
            return;
          end
          if (m_valid[s] && m_dirty[s]) flush_slot(s);
          push_res(c.zero_fill ? wbc_pkg::K_ZFILL : wbc_pkg::K_READ, c.block, s,
                   wbc_pkg::ST_OK, 1'b0);
          m_tag[s] = c.block;
          m_valid[s] = 1'b1;
          m_dirty[s] = c.zero_fill;
          m_in_txn[s] = 1'b0;
          m_pins[s] = '0;
        end
        if (m_pins[s] != 8'hff) m_pins[s]++;
        move_to_hot(s);
        push_res(wbc_pkg::K_DONE, '0, s, wbc_pkg::ST_OK, 1'b1);
      end
      wbc_pkg::CMD_PUT: begin
        s = lookup_slot(c.block);
        if (s >= 0 && m_pins[s] != 0) m_pins[s]--;
        push_res(wbc_pkg::K_DONE, '0, (s >= 0) ? s : 0, wbc_pkg::ST_OK, 1'b1);
      end
      wbc_pkg::CMD_MARK: begin
        s = lookup_slot(c.block);
        if (s < 0) begin
          push_res(wbc_pkg::K_DONE, '0, 0, wbc_pkg::ST_NOTC, 1'b1);
          return;
        end
        m_dirty[s] = 1'b1;
        if (m_txn_open && !m_in_txn[s]) begin
          if (m_txn_n >= TxnDepth) begin
            push_res(wbc_pkg::K_DONE, '0, s, wbc_pkg::ST_FULL, 1'b1);
            return;
          end
          m_in_txn[s] = 1'b1;
          m_txn[m_txn_n] = c.block;
          m_txn_n++;
        end
        push_res(wbc_pkg::K_DONE, '0, s, wbc_pkg::ST_OK, 1'b1);
      end
      wbc_pkg::CMD_BEGIN: begin
        m_txn_open = 1'b1;
        m_txn_n = 0;
        push_res(wbc_pkg::K_DONE, '0, 0, wbc_pkg::ST_OK, 1'b1);
      end
      wbc_pkg::CMD_COMMIT: begin
        for (int i = 0; i < m_txn_n; i++) begin
          s = lookup_slot(m_txn[i]);
          if (s < 0) begin
            bad = 1'b1;
            break;
          end
          m_in_txn[s] = 1'b0;
          if (m_dirty[s]) flush_slot(s);
        end
        m_txn_open = 1'b0;
        m_txn_n = 0;
        if (bad) push_res(wbc_pkg::K_DONE, '0, 0, wbc_pkg::ST_NOTC, 1'b1);
        else push_res(wbc_pkg::K_FLUSH, '0, 0, wbc_pkg::ST_OK, 1'b1);
      end
      wbc_pkg::CMD_ABORT: begin
        for (int i = 0; i < m_txn_n; i++) begin
          s = lookup_slot(m_txn[i]);
          if (s >= 0) begin
            m_dirty[s] = 1'b0;
            m_in_txn[s] = 1'b0;
            m_pins[s] = '0;
            m_valid[s] = 1'b0;
          end
        end
        m_txn_open = 1'b0;
        m_txn_n = 0;
        push_res(wbc_pkg::K_DONE, '0, 0, wbc_pkg::ST_OK, 1'b1);
      end
      wbc_pkg::CMD_SYNC: begin
        for (int i = 0; i < Slots; i++)
          if (m_valid[i] && m_dirty[i]) flush_slot(i);
        push_res(wbc_pkg::K_FLUSH, '0, 0, wbc_pkg::ST_OK, 1'b1);
      end
      default: push_res(wbc_pkg::K_DONE, '0, 0, wbc_pkg::ST_OK, 1'b1);
    endcase
  endfunction

  function automatic void queue_cmd(logic [2:0] op, logic [BlkW-1:0] b, logic zf);
    cmd_word_t c;
    c.command = op;
    c.block = b;
    c.zero_fill = zf;
    pending_cmds.push_back(c);
  endfunction

  function automatic logic [BlkW-1:0] pick_block();
    if ($urandom_range(99) < 75) return blk_pool[$urandom_range(blk_pool.size() - 1)];
    return BlkW'({$urandom, $urandom});
  endfunction

  function automatic logic [2:0] pick_txn_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return wbc_pkg::CMD_GET;
    if (r < 65) return wbc_pkg::CMD_PUT;
    return wbc_pkg::CMD_MARK;
  endfunction

  // open transaction, random body, closed by commit or abort; returns word count
  function automatic int unsigned queue_txn_sequence();
    int unsigned n;
    n = $urandom_range(2, 20);
    queue_cmd(wbc_pkg::CMD_BEGIN, pick_block(), 1'($urandom_range(1)));
    for (int i = 0; i < n; i++) queue_cmd(pick_txn_op(), pick_block(), 1'($urandom_range(1)));
    queue_cmd($urandom_range(99) < 65 ? wbc_pkg::CMD_COMMIT : wbc_pkg::CMD_ABORT,
              pick_block(), 1'($urandom_range(1)));
    return n + 2;
  endfunction

  function automatic void queue_random_phase(int unsigned count);
    int unsigned made;
    int unsigned r;
    made = 0;
    while (made < count) begin
      r = $urandom_range(99);
      if (r < 55) made += queue_txn_sequence();
      else if (r < 90) begin
        queue_cmd(3'($urandom_range(7)), pick_block(), 1'($urandom_range(1)));
        made++;
      end else begin
        queue_cmd(wbc_pkg::CMD_SYNC, pick_block(), 1'($urandom_range(1)));
        made++;
      end
    end
  endfunction

  // wait at rising edges until every word is sent and every result is back
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || expected_res.size() != 0 || cmd.valid);
  endtask

  // wait until the block is quiet, then write device_blocks
  task automatic write_dev_blocks(logic [BlkW-1:0] v);
    wait_quiet();
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    m_dev_blocks = v;
  endtask

  // command driver: the next word may go out at the falling edge after acceptance, unless the driver idles
  always @(posedge clk_i) cmd_taken <= cmd.valid && cmd.ready;

  always @(negedge clk_i) begin
    if (rst_ni && (!cmd.valid || cmd_taken)) begin
      if (pending_cmds.size() > 0 && !idle_now()) begin
        cmd.valid <= 1'b1;
        cmd.command <= pending_cmds[0].command;
        cmd.block <= pending_cmds[0].block;
        cmd.zero_fill <= pending_cmds[0].zero_fill;
        void'(pending_cmds.pop_front());
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // result ready: random idling plus one long hold-off so the block backs up
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else if (stall_left > 0) begin
      res.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && res_seen >= 60) begin
      res.ready <= 1'b0;
      stall_left <= StallCycles;
      stall_done <= 1'b1;
    end else begin
      res.ready <= !idle_now();
    end
  end

  // sample both channels at the rising edge, predict and check
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd.valid && cmd.ready)
        cache_predict('{command: cmd.command, block: cmd.block, zero_fill: cmd.zero_fill});
      if (res.valid && res.ready) begin
        res_seen <= res_seen + 1;
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected word kind %0d block %h slot %0d status %0d last %0b",
                   $time, res.kind, res.block_number, res.slot, res.status, res.last);
          errors <= errors + 1;
        end else begin
          if (res.kind !== expected_res[0].kind || res.block_number !== expected_res[0].block_number
              || res.slot !== expected_res[0].slot || res.status !== expected_res[0].status
              || res.last !== expected_res[0].last) begin
            $display("%0t: mismatch exp kind %0d block %h slot %0d status %0d last %0b",
                     $time, expected_res[0].kind, expected_res[0].block_number,
                     expected_res[0].slot, expected_res[0].status, expected_res[0].last);
            $display("%0t:          act kind %0d block %h slot %0d status %0d last %0b",
                     $time, res.kind, res.block_number, res.slot, res.status, res.last);
            errors <= errors + 1;
          end
          void'(expected_res.pop_front());
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      hang_count <= 0;
    end else if (hang_count >= HangLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  initial begin
    cmd.valid = 1'b0;
    cmd.command = wbc_pkg::CMD_GET;
    cmd.block = '0;
    cmd.zero_fill = 1'b0;
    res.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    errors = 0;
    res_seen = 0;
    stall_left = 0;
    stall_done = 1'b0;
    hang_count = 0;
    cmd_taken = 1'b0;
    calm = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      m_tag[i] = '0;
      m_valid[i] = 1'b0;
      m_pins[i] = '0;
      m_dirty[i] = 1'b0;
      m_in_txn[i] = 1'b0;
      m_rank[i] = i;
    end
    for (int i = 0; i < TxnDepth; i++) m_txn[i] = '0;
    m_txn_n = 0;
    m_txn_open = 1'b0;
    m_dev_blocks = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // device size still zero: every get is out of range
    queue_cmd(wbc_pkg::CMD_GET, 48'd0, 1'b0);
    queue_cmd(wbc_pkg::CMD_GET, BlkMax, 1'b1);
    write_dev_blocks(48'd40);

    // directed: hits, misses, range edge, puts, marks, transactions, sync, an unknown command
    queue_cmd(wbc_pkg::CMD_GET, 48'd0, 1'b0);
    queue_cmd(wbc_pkg::CMD_GET, 48'd1, 1'b1);
    queue_cmd(wbc_pkg::CMD_GET, 48'd39, 1'b0);
    queue_cmd(wbc_pkg::CMD_GET, 48'd40, 1'b0);
    queue_cmd(wbc_pkg::CMD_GET, 48'd0, 1'b0);
    queue_cmd(wbc_pkg::CMD_PUT, 48'd0, 1'b0);
    queue_cmd(wbc_pkg::CMD_PUT, 48'd0, 1'b0);
    queue_cmd(wbc_pkg::CMD_PUT, 48'd0, 1'b0);      // unpinned, stays at zero
    queue_cmd(wbc_pkg::CMD_PUT, 48'd77, 1'b0);     // not cached
    queue_cmd(wbc_pkg::CMD_MARK, 48'd77, 1'b0);    // not cached
    queue_cmd(wbc_pkg::CMD_MARK, 48'd0, 1'b0);     // dirty outside a transaction
    queue_cmd(wbc_pkg::CMD_SYNC, 48'd0, 1'b0);
    queue_cmd(wbc_pkg::CMD_BEGIN, 48'd0, 1'b0);
    queue_cmd(wbc_pkg::CMD_MARK, 48'd1, 1'b0);
    queue_cmd(wbc_pkg::CMD_MARK, 48'd39, 1'b0);
    queue_cmd(wbc_pkg::CMD_BEGIN, 48'd0, 1'b0);    // reopen empties the list, marks stay
    queue_cmd(wbc_pkg::CMD_MARK, 48'd0, 1'b0);
    queue_cmd(wbc_pkg::CMD_COMMIT, 48'd0, 1'b0);
    queue_cmd(wbc_pkg::CMD_BEGIN, 48'd0, 1'b0);
    queue_cmd(wbc_pkg::CMD_GET, 48'd2, 1'b0);
    queue_cmd(wbc_pkg::CMD_MARK, 48'd2, 1'b0);
    queue_cmd(wbc_pkg::CMD_ABORT, 48'd0, 1'b0);
    queue_cmd(wbc_pkg::CMD_COMMIT, 48'd0, 1'b0);   // nothing open
    queue_cmd(wbc_pkg::CMD_ABORT, 48'd0, 1'b0);
    queue_cmd(wbc_pkg::CMD_SYNC, 48'd0, 1'b0);
    queue_cmd(CmdUnknown, BlkMax, 1'b1);

    // small device, small block pool: evictions, full lists, pinned-out cache
    for (int i = 0; i < 44; i++) blk_pool.push_back(BlkW'(i));
    write_dev_blocks(48'd40);
    queue_random_phase(40);

    // whole block range: wide block numbers, top value out of range, no idling
    write_dev_blocks(BlkMax);
    calm = 1'b1;
    blk_pool.delete();
    for (int i = 0; i < 30; i++) blk_pool.push_back(BlkW'({$urandom, $urandom}));
    blk_pool.push_back(BlkMax);
    blk_pool.push_back(BlkMax - 1);
    blk_pool.push_back(48'd0);
    queue_random_phase(40);
    queue_cmd(wbc_pkg::CMD_SYNC, 48'd0, 1'b0);

    wait_quiet();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
